### sv/owt_pkg.sv
package owt_pkg;

  localparam int unsigned WaitW  = 10;
  localparam int unsigned TimerW = 20;
  localparam int unsigned RawW   = 16;
  localparam int unsigned DegW   = 12;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitW   = 3;

  localparam logic [WaitW-1:0]  WaitMsReset = 10'd200;
  localparam logic [TimerW-1:0] UsPerMs     = 20'd1000;

  localparam logic [ByteW-1:0] CmdSkipRom  = 8'hCC;
  localparam logic [ByteW-1:0] CmdConvert  = 8'h44;
  localparam logic [ByteW-1:0] CmdReadPad  = 8'hBE;

  localparam logic [TimerW-1:0] ResetUs    = 20'd500;
  localparam logic [TimerW-1:0] SlotUs     = 20'd60;
  localparam logic [TimerW-1:0] ShortUs    = 20'd5;
  localparam logic [TimerW-1:0] ReadTailUs = 20'd50;

  localparam logic [BitW-1:0] LastBit = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE = 5'd0,
    ST_R1L  = 5'd1,
    ST_R1H  = 5'd2,
    ST_W1L  = 5'd3,
    ST_W1H  = 5'd4,
    ST_W2L  = 5'd5,
    ST_W2H  = 5'd6,
    ST_WAIT = 5'd7,
    ST_R2L  = 5'd8,
    ST_R2H  = 5'd9,
    ST_W3L  = 5'd10,
    ST_W3H  = 5'd11,
    ST_W4L  = 5'd12,
    ST_W4H  = 5'd13,
    ST_RD0L = 5'd14,
    ST_RD0G = 5'd15,
    ST_RD0T = 5'd16,
    ST_RD1L = 5'd17,
    ST_RD1G = 5'd18,
    ST_RD1T = 5'd19
  } step_e;

  typedef struct packed {
    logic                   drive_low;
    logic                   busy_res;
    logic                   result_ready;
    logic [RawW-1:0]        raw_reading;
    logic signed [DegW-1:0] whole_degrees;
  } result_t;

  // Sixteenths of a degree to whole degrees, truncated toward zero.
  function automatic logic signed [DegW-1:0] to_degrees(input logic [RawW-1:0] raw);
    logic [RawW-1:0] mag;
    logic [DegW-1:0] whole;
    begin
      mag   = raw[RawW-1] ? (~raw + 16'd1) : raw;
      whole = mag[RawW-1:4];
      to_degrees = raw[RawW-1] ? $signed(~whole + 12'd1) : $signed(whole);
    end
  endfunction

endpackage

### sv/owt_if.sv
interface owt_in_if;
  logic valid;
  logic ready;
  logic us_tick;
  logic start_request;
  logic line_level;

  modport source (output valid, output us_tick, output start_request, output line_level,
                  input ready);
  modport sink   (input valid, input us_tick, input start_request, input line_level,
                  output ready);
endinterface

interface owt_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    drive_low;
  logic                                    busy_res;
  logic                                    result_ready;
  logic [owt_pkg::RawW-1:0]                raw_reading;
  logic signed [owt_pkg::DegW-1:0]         whole_degrees;

  modport source (output valid, output drive_low, output busy_res, output result_ready,
                  output raw_reading, output whole_degrees, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input result_ready,
                  input raw_reading, input whole_degrees, output ready);
endinterface

### sv/owt_core.sv
module owt_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         us_tick_i,
  input  logic                         start_request_i,
  input  logic                         line_level_i,
  input  logic [owt_pkg::TimerW-1:0]   wait_limit_i,
  output owt_pkg::result_t             result_o
);

  owt_pkg::step_e                   st_q, st_d;
  logic [owt_pkg::BitW-1:0]         bit_q, bit_d;
  logic [owt_pkg::ByteW-1:0]        shift_q, shift_d;
  logic [owt_pkg::TimerW-1:0]       slot_q, slot_d;
  logic [owt_pkg::ByteW-1:0]        low_q, low_d;
  logic [owt_pkg::RawW-1:0]         raw_q, raw_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= owt_pkg::ST_IDLE;
      bit_q   <= '0;
      shift_q <= '0;
      slot_q  <= '0;
      low_q   <= '0;
      raw_q   <= '0;
    end else if (step_i) begin
      st_q    <= st_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      slot_q  <= slot_d;
      low_q   <= low_d;
      raw_q   <= raw_d;
    end
  end

  always_comb begin
    logic [owt_pkg::TimerW-1:0] inc;
    logic                       wdone;
    logic                       rdone;
    logic                       ready;
    owt_pkg::step_e             wlow;

    st_d    = st_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    slot_d  = slot_q;
    low_d   = low_q;
    raw_d   = raw_q;
    inc     = slot_q + 20'd1;
    wdone   = 1'b0;
    rdone   = 1'b0;
    ready   = 1'b0;
    wlow    = owt_pkg::ST_W1L;

    if (st_q == owt_pkg::ST_IDLE || st_q > owt_pkg::ST_RD1T) begin
      st_d = owt_pkg::ST_IDLE;
      if (start_request_i) begin
        st_d    = owt_pkg::ST_R1L;
        slot_d  = '0;
        bit_d   = '0;
        shift_d = '0;
      end
    end else if (us_tick_i) begin
      slot_d = inc;
      case (st_q)
        owt_pkg::ST_R1L, owt_pkg::ST_R2L: begin
          if (inc >= owt_pkg::ResetUs) begin
            st_d   = owt_pkg::step_e'(st_q + 5'd1);
            slot_d = '0;
          end
        end
        owt_pkg::ST_R1H, owt_pkg::ST_R2H: begin
          if (inc >= owt_pkg::ResetUs) begin
            st_d    = (st_q == owt_pkg::ST_R1H) ? owt_pkg::ST_W1L : owt_pkg::ST_W3L;
            shift_d = owt_pkg::CmdSkipRom;
            bit_d   = '0;
            slot_d  = '0;
          end
        end
        owt_pkg::ST_W1L, owt_pkg::ST_W2L, owt_pkg::ST_W3L, owt_pkg::ST_W4L: begin
          wlow = st_q;
          if (shift_q[0]) begin
            if (inc >= owt_pkg::ShortUs) begin
              st_d   = owt_pkg::step_e'(st_q + 5'd1);
              slot_d = '0;
            end
          end else if (inc >= owt_pkg::SlotUs) begin
            wdone = 1'b1;
          end
        end
        owt_pkg::ST_W1H, owt_pkg::ST_W2H, owt_pkg::ST_W3H, owt_pkg::ST_W4H: begin
          wlow  = owt_pkg::step_e'(st_q - 5'd1);
          wdone = (inc >= owt_pkg::SlotUs);
        end
        owt_pkg::ST_WAIT: begin
          if (inc >= wait_limit_i) begin
            st_d   = owt_pkg::ST_R2L;
            slot_d = '0;
          end
        end
        owt_pkg::ST_RD0L, owt_pkg::ST_RD1L: begin
          if (inc >= owt_pkg::ShortUs) begin
            st_d   = owt_pkg::step_e'(st_q + 5'd1);
            slot_d = '0;
          end
        end
        owt_pkg::ST_RD0G, owt_pkg::ST_RD1G: begin
          if (inc >= owt_pkg::ShortUs) begin
            shift_d = {line_level_i, shift_q[7:1]};
            st_d    = owt_pkg::step_e'(st_q + 5'd1);
            slot_d  = '0;
          end
        end
        owt_pkg::ST_RD0T, owt_pkg::ST_RD1T: begin
          rdone = (inc >= owt_pkg::ReadTailUs);
        end
        default: begin
          st_d = owt_pkg::ST_IDLE;
        end
      endcase
    end

    if (wdone) begin
      shift_d = {1'b0, shift_q[7:1]};
      slot_d  = '0;
      if (bit_q != owt_pkg::LastBit) begin
        bit_d = bit_q + 3'd1;
        st_d  = wlow;
      end else begin
        bit_d = '0;
        case (wlow)
          owt_pkg::ST_W1L: begin
            st_d    = owt_pkg::ST_W2L;
            shift_d = owt_pkg::CmdConvert;
          end
          owt_pkg::ST_W2L: st_d = owt_pkg::ST_WAIT;
          owt_pkg::ST_W3L: begin
            st_d    = owt_pkg::ST_W4L;
            shift_d = owt_pkg::CmdReadPad;
          end
          default: begin
            st_d    = owt_pkg::ST_RD0L;
            shift_d = '0;
          end
        endcase
      end
    end

    if (rdone) begin
      slot_d = '0;
      if (bit_q != owt_pkg::LastBit) begin
        bit_d = bit_q + 3'd1;
        st_d  = (st_q == owt_pkg::ST_RD0T) ? owt_pkg::ST_RD0L : owt_pkg::ST_RD1L;
      end else begin
        bit_d   = '0;
        shift_d = '0;
        if (st_q == owt_pkg::ST_RD0T) begin
          low_d = shift_q;
          st_d  = owt_pkg::ST_RD1L;
        end else begin
          raw_d = {shift_q, low_q};
          st_d  = owt_pkg::ST_IDLE;
          ready = 1'b1;
        end
      end
    end

    result_o.drive_low     = (st_d == owt_pkg::ST_R1L) || (st_d == owt_pkg::ST_R2L) ||
                             (st_d == owt_pkg::ST_W1L) || (st_d == owt_pkg::ST_W2L) ||
                             (st_d == owt_pkg::ST_W3L) || (st_d == owt_pkg::ST_W4L) ||
                             (st_d == owt_pkg::ST_RD0L) || (st_d == owt_pkg::ST_RD1L);
    result_o.busy_res      = (st_d != owt_pkg::ST_IDLE);
    result_o.result_ready  = ready;
    result_o.raw_reading   = raw_d;
    result_o.whole_degrees = owt_pkg::to_degrees(raw_d);
  end

endmodule

### sv/onewire_temperature_reader_unit.sv
// Each beat accepted into the input register gives one result beat through the result register.
// Throughput: one beat per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// The sequencer state changes once per beat, in the cycle the beat leaves the input register.
// Reset (rst_ni low, asynchronous): sequencer idle, reading cleared to zero,
// conversion wait back to 200 ms, both registers empty.
module onewire_temperature_reader_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  owt_in_if.sink                      in_i,
  owt_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [owt_pkg::WaitW-1:0]   cfg_wdata_i
);

  logic                          in_vld_q;
  logic                          tick_q;
  logic                          start_q;
  logic                          line_q;
  logic                          out_vld_q;
  owt_pkg::result_t              res_q;
  owt_pkg::result_t              res_d;
  logic [owt_pkg::TimerW-1:0]    wait_limit_q;
  logic                          advance;

  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_limit_q <= owt_pkg::TimerW'({10'd0, owt_pkg::WaitMsReset} * owt_pkg::UsPerMs);
    end else if (cfg_we_i) begin
      wait_limit_q <= owt_pkg::TimerW'({10'd0, cfg_wdata_i} * owt_pkg::UsPerMs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      tick_q  <= in_i.us_tick;
      start_q <= in_i.start_request;
      line_q  <= in_i.line_level;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  owt_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .us_tick_i       (tick_q),
    .start_request_i (start_q),
    .line_level_i    (line_q),
    .wait_limit_i    (wait_limit_q),
    .result_o        (res_d)
  );

  assign out_o.valid         = out_vld_q;
  assign out_o.drive_low     = res_q.drive_low;
  assign out_o.busy_res      = res_q.busy_res;
  assign out_o.result_ready  = res_q.result_ready;
  assign out_o.raw_reading   = res_q.raw_reading;
  assign out_o.whole_degrees = res_q.whole_degrees;

endmodule

### sv/owt_checker.sv
module owt_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic                               drive_low_i,
  input logic                               busy_res_i,
  input logic                               result_ready_i,
  input logic [owt_pkg::RawW-1:0]           raw_reading_i,
  input logic signed [owt_pkg::DegW-1:0]    whole_degrees_i
);

  // A finished reading closes the sequence.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_ready_i |-> !busy_res_i)
    else $error("result_ready while busy");

  // The line is only pulled while a sequence runs.
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && drive_low_i |-> busy_res_i)
    else $error("drive_low while idle");

  // Positive readings scale by a plain shift.
  a_deg_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !raw_reading_i[15] |->
      whole_degrees_i == $signed({1'b0, raw_reading_i[14:4]}))
    else $error("whole_degrees mismatch");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

endmodule

bind onewire_temperature_reader_unit owt_checker u_owt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .drive_low_i     (out_o.drive_low),
  .busy_res_i      (out_o.busy_res),
  .result_ready_i  (out_o.result_ready),
  .raw_reading_i   (out_o.raw_reading),
  .whole_degrees_i (out_o.whole_degrees)
);

### dv/tb_onewire_temperature_reader_unit.sv
`timescale 1ns / 1ps

module tb_onewire_temperature_reader_unit;
  import owt_pkg::*;

  localparam int PulseUs    = 500;
  localparam int BitSlotUs  = 60;
  localparam int OneLowUs   = 5;
  localparam int ReadRestUs = 50;
  localparam int UsInMs     = 1000;

  localparam logic [7:0] OpSkipRom = 8'hCC;
  localparam logic [7:0] OpConvert = 8'h44;
  localparam logic [7:0] OpReadPad = 8'hBE;

  typedef enum logic {ROW_BEAT, ROW_MEASURE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [9:0]  wait_ms;
    logic [15:0] word;
    logic [6:0]  tick_pct;
    logic        typed;
    logic [15:0] exp_raw;
    logic [11:0] exp_deg;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [9:0] cfg_wdata;

  owt_in_if  in_if ();
  owt_out_if out_if ();

  onewire_temperature_reader_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  step_e       seq_step  = ST_IDLE;
  logic [2:0]  seq_bit   = '0;
  logic [7:0]  seq_shift = '0;
  logic [19:0] seq_timer = '0;
  logic [7:0]  seq_low   = '0;
  logic [15:0] seq_raw   = '0;
  logic [9:0]  wait_ms   = 10'd200;

  result_t expected_results [$];
  int      mismatches;
  bit      src_gaps;
  bit      sink_gaps;
  bit      hold_long;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void load_byte(input step_e low_step, input logic [7:0] value);
    seq_step  = low_step;
    seq_shift = value;
    seq_bit   = '0;
    seq_timer = '0;
  endfunction

  function automatic void finish_write_bit(input step_e low_step);
    seq_shift = seq_shift >> 1;
    seq_timer = '0;
    if (seq_bit != 3'd7) begin
      seq_bit  = seq_bit + 3'd1;
      seq_step = low_step;
    end else begin
      seq_bit = '0;
      case (low_step)
        ST_W1L: load_byte(ST_W2L, OpConvert);
        ST_W2L: seq_step = ST_WAIT;
        ST_W3L: load_byte(ST_W4L, OpReadPad);
        default: begin
          seq_step  = ST_RD0L;
          seq_shift = '0;
        end
      endcase
    end
  endfunction

  function automatic result_t predict_beat(input logic tick, input logic start,
                                           input logic lvl);
    result_t     res;
    step_e       st;
    logic        done;
    logic [16:0] mag;
    done = 1'b0;
    st   = seq_step;
    if (st == ST_IDLE) begin
      if (start) begin
        seq_step  = ST_R1L;
        seq_timer = '0;
        seq_bit   = '0;
        seq_shift = '0;
      end
    end else if (tick) begin
      seq_timer = seq_timer + 20'd1;
      case (st)
        ST_R1L, ST_R2L: begin
          if (seq_timer >= PulseUs) begin
            seq_step  = step_e'(st + 5'd1);
            seq_timer = '0;
          end
        end
        ST_R1H: if (seq_timer >= PulseUs) load_byte(ST_W1L, OpSkipRom);
        ST_R2H: if (seq_timer >= PulseUs) load_byte(ST_W3L, OpSkipRom);
        ST_W1L, ST_W2L, ST_W3L, ST_W4L: begin
          if (seq_shift[0]) begin
            if (seq_timer >= OneLowUs) begin
              seq_step  = step_e'(st + 5'd1);
              seq_timer = '0;
            end
          end else if (seq_timer >= BitSlotUs) begin
            finish_write_bit(st);
          end
        end
        ST_W1H, ST_W2H, ST_W3H, ST_W4H: begin
          if (seq_timer >= BitSlotUs) finish_write_bit(step_e'(st - 5'd1));
        end
        ST_WAIT: begin
          if (32'(seq_timer) >= 32'(wait_ms) * UsInMs) begin
            seq_step  = ST_R2L;
            seq_timer = '0;
          end
        end
        ST_RD0L, ST_RD1L: begin
          if (seq_timer >= OneLowUs) begin
            seq_step  = step_e'(st + 5'd1);
            seq_timer = '0;
          end
        end
        ST_RD0G, ST_RD1G: begin
          if (seq_timer >= OneLowUs) begin
            seq_shift = {lvl, seq_shift[7:1]};
            seq_step  = step_e'(st + 5'd1);
            seq_timer = '0;
          end
        end
        ST_RD0T, ST_RD1T: begin
          if (seq_timer >= ReadRestUs) begin
            seq_timer = '0;
            if (seq_bit != 3'd7) begin
              seq_bit  = seq_bit + 3'd1;
              seq_step = (st == ST_RD0T) ? ST_RD0L : ST_RD1L;
            end else begin
              seq_bit = '0;
              if (st == ST_RD0T) begin
                seq_low   = seq_shift;
                seq_shift = '0;
                seq_step  = ST_RD1L;
              end else begin
                seq_raw   = {seq_shift, seq_low};
                seq_shift = '0;
                seq_step  = ST_IDLE;
                done      = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    st = seq_step;
    res.drive_low = (st == ST_R1L || st == ST_R2L || st == ST_W1L || st == ST_W2L ||
                     st == ST_W3L || st == ST_W4L || st == ST_RD0L || st == ST_RD1L);
    res.busy_res     = (st != ST_IDLE);
    res.result_ready = done;
    res.raw_reading  = seq_raw;
    if (seq_raw[15]) begin
      mag = {1'b0, ~seq_raw} + 17'd1;
      res.whole_degrees = 12'(17'd0 - (mag >> 4));
    end else begin
      res.whole_degrees = seq_raw[15:4];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100) begin
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, field, got, want);
    end
    mismatches++;
  endtask

  task automatic offer_beat(input logic tick, input logic start, input logic lvl,
                            output result_t res);
    if (src_gaps && $urandom_range(0, 19) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.us_tick       <= tick;
    in_if.start_request <= start;
    in_if.line_level    <= lvl;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    res = predict_beat(tick, start, lvl);
  endtask

  task automatic set_wait_ms(input logic [9:0] ms);
    in_if.valid <= 1'b0;
    wait (expected_results.size() == 0);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    wait_ms  = ms;
  endtask

  // Feed the line from word while a read slot is sampling it.
  // Cut a full-scale wait short by rewriting the register mid-wait.
  task automatic run_measurement(input logic [9:0] ms, input logic [15:0] word, input int pct,
                                 input bit typed, input logic [15:0] exp_raw,
                                 input logic [11:0] exp_deg);
    result_t res;
    logic    lvl;
    bit      cut;
    set_wait_ms(ms);
    cut = (ms == 10'd1023);
    do begin
      if (cut && seq_step == ST_WAIT && seq_timer >= 20'd200) begin
        set_wait_ms(10'd0);
        cut = 1'b0;
      end
      if (seq_step == ST_RD0G || seq_step == ST_RD1G) begin
        lvl = word[{seq_step == ST_RD1G, seq_bit}];
      end else begin
        lvl = 1'($urandom_range(0, 1));
      end
      offer_beat(1'($urandom_range(1, 100) <= pct),
                 seq_step == ST_IDLE || $urandom_range(0, 3) == 0, lvl, res);
      if (typed && res.result_ready) begin
        res.raw_reading   = exp_raw;
        res.whole_degrees = exp_deg;
      end
      expected_results.push_back(res);
    end while (seq_step != ST_IDLE);
  endtask

  initial begin
    result_t want;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch("beat with nothing pending", '0, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_if.drive_low !== want.drive_low)
            report_mismatch("drive_low", out_if.drive_low, want.drive_low);
          if (out_if.busy_res !== want.busy_res)
            report_mismatch("busy_res", out_if.busy_res, want.busy_res);
          if (out_if.result_ready !== want.result_ready)
            report_mismatch("result_ready", out_if.result_ready, want.result_ready);
          if (out_if.raw_reading !== want.raw_reading)
            report_mismatch("raw_reading", out_if.raw_reading, want.raw_reading);
          if (out_if.whole_degrees !== want.whole_degrees)
            report_mismatch("whole_degrees", 12'(out_if.whole_degrees),
                            12'(want.whole_degrees));
        end
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (sink_gaps && $urandom_range(0, 19) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    row_t    plan [9];
    result_t res;
    plan[0] = '{ROW_BEAT,    10'd0,    16'h0000, 7'd0,   1'b1, 16'h0000, 12'h000};
    plan[1] = '{ROW_BEAT,    10'd0,    16'h0000, 7'd100, 1'b1, 16'h0000, 12'h000};
    plan[2] = '{ROW_MEASURE, 10'd0,    16'h7FFF, 7'd100, 1'b1, 16'h7FFF, 12'h7FF};
    plan[3] = '{ROW_MEASURE, 10'd1,    16'h8000, 7'd60,  1'b1, 16'h8000, 12'h800};
    plan[4] = '{ROW_MEASURE, 10'd0,    16'hFFFF, 7'd80,  1'b1, 16'hFFFF, 12'h000};
    plan[5] = '{ROW_MEASURE, 10'd2,    16'hFFF0, 7'd100, 1'b1, 16'hFFF0, 12'hFFF};
    plan[6] = '{ROW_MEASURE, 10'd0,    16'h0000, 7'd50,  1'b1, 16'h0000, 12'h000};
    plan[7] = '{ROW_MEASURE, 10'd1023, 16'h0191, 7'd100, 1'b1, 16'h0191, 12'h019};
    plan[8] = '{ROW_MEASURE, 10'd0,    16'hFE6F, 7'd90,  1'b1, 16'hFE6F, 12'hFE7};

    in_if.valid         <= 1'b0;
    in_if.us_tick       <= 1'b0;
    in_if.start_request <= 1'b0;
    in_if.line_level    <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    rst_ni              <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      src_gaps  = (plan[i].wait_ms < 10'd10);
      sink_gaps = src_gaps;
      if (plan[i].kind == ROW_BEAT) begin
        offer_beat(1'($urandom_range(1, 100) <= plan[i].tick_pct), 1'b0,
                   1'($urandom_range(0, 1)), res);
        res               = '0;
        res.raw_reading   = plan[i].exp_raw;
        res.whole_degrees = plan[i].exp_deg;
        expected_results.push_back(res);
      end else begin
        run_measurement(plan[i].wait_ms, plan[i].word, plan[i].tick_pct, plan[i].typed,
                        plan[i].exp_raw, plan[i].exp_deg);
      end
    end

    for (int m = 0; m < 12; m++) begin
      src_gaps  = (m < 9);
      sink_gaps = (m < 9);
      if (m == 2) hold_long = 1'b1;
      repeat ($urandom_range(5, 40)) begin
        offer_beat(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)), res);
        expected_results.push_back(res);
      end
      run_measurement(10'($urandom_range(0, 3)), 16'($urandom), $urandom_range(50, 100),
                      1'b0, '0, '0);
    end

    in_if.valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
